/* sv/srrc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the slotted resource reservation calendar.
package srrc_pkg;

  localparam int SRRC_NUM_SLOTS = 256;

  localparam int TIME_W  = 32;
  localparam int SCALE_W = 16;
  localparam int CFG_W   = 32;
  localparam int ACT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_CHECK   = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_FORCE   = 2'd2,
    ACT_ADVANCE = 2'd3
  } action_t;

  localparam logic REG_SCALE    = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GO,
    ST_WAIT,
    ST_PLAN,
    ST_WALK,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

/* sv/slotted_resource_reservation_calendar.sv */
`timescale 1ns / 1ps
// Top level of the slotted resource reservation calendar.
//
// The calendar keeps one 32-bit load counter per slot in a single-port-write
// memory with a registered read, plus the current time. An item is taken at a
// rising edge with start high and busy low; its one result appears on accepted
// for exactly one cycle with done high, and the receiver cannot hold it off.
// After reset the block sweeps the memory to zero, one slot per cycle, and busy
// stays high until the sweep ends; configuration writes are taken at any time.
// Each slot number is found with a shared divider that yields one bit per
// cycle: the time is divided by the ring length (NUM_SLOTS times the slot
// scale), and the remainder by the slot scale. A check, insert or force insert
// needs three slot numbers, then walks the covered slots at one memory access
// per cycle; an insert whose test passes walks twice, once to test and once
// to add. A time advance needs two slot numbers and then clears the slots
// passed, one per cycle; a full ring advance skips the division and clears
// all NUM_SLOTS slots. A check or insert request that reaches past the ring
// is refused at once: its result is on the ports in the cycle right after the
// transfer. The worst case is an insert over the whole ring.
module slotted_resource_reservation_calendar
  import srrc_pkg::*;
#(
  parameter int NUM_SLOTS = SRRC_NUM_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action,
  input  logic [TIME_W-1:0] start_offset,
  input  logic [TIME_W-1:0] span_length,
  input  logic [TIME_W-1:0] load_amount,
  input  logic [TIME_W-1:0] new_time,
  output logic              done,
  output logic              accepted
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int RT_W  = CNT_W + SCALE_W;
  localparam int DVS_W = RT_W;
  localparam int SUM_W = TIME_W + 2;

  // Configuration registers.
  logic [SCALE_W-1:0] slot_scale;
  logic [TIME_W-1:0]  capacity;
  logic [SCALE_W-1:0] eff_scale;
  logic [SCALE_W-1:0] scale_m1;

  // Length of the whole ring in time units, always in step with the scale.
  logic [RT_W-1:0] ring_time;

  // Sequencer and the item being served.
  state_t            state, state_next;
  action_t           op;
  logic [TIME_W-1:0] now_time;
  logic [TIME_W-1:0] st_time;
  logic [TIME_W-1:0] span;
  logic [TIME_W-1:0] amount;
  logic [TIME_W-1:0] target_time;
  logic [TIME_W-1:0] et_time;
  logic              full_adv;
  logic              pass;
  logic              fail;
  logic [1:0]        job;
  logic [1:0]        job_last;
  logic              phase;
  logic [IDX_W-1:0]  tl;
  logic [IDX_W-1:0]  sl;
  logic [IDX_W-1:0]  el;

  // Slot walker.
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] seg_end;
  logic             wrap;
  logic             second;
  logic             issue;
  logic             seg_next;
  logic             walk_end;
  logic             clear_mode;
  logic             add_mode;

  // Slot memory and its access pipeline.
  logic [TIME_W-1:0] slot_load [NUM_SLOTS];
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_addr;
  logic [TIME_W-1:0] rd_data;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [TIME_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  clr_idx;
  logic              over;

  // Checks made on the input ports in the cycle an item is taken.
  logic [SUM_W-1:0] reach;
  logic             req_too_long;
  logic             adv_full;
  logic             is_check;

  // Divider hookup.
  logic              div_go;
  logic              div_done;
  logic [TIME_W-1:0] div_q;
  logic [DVS_W-1:0]  div_rem;
  logic [TIME_W-1:0] div_dvd;
  logic [DVS_W-1:0]  div_dvs;

  assign eff_scale = (slot_scale == '0) ? SCALE_W'(1) : slot_scale;
  assign scale_m1  = eff_scale - SCALE_W'(1);
  assign ring_time = RT_W'(NUM_SLOTS) * RT_W'(eff_scale);

  // A check or insert request is refused outright when start, span and two
  // partial slots together reach past the ring.
  assign reach = SUM_W'(start_offset) + SUM_W'(span_length) + (SUM_W'(scale_m1) << 1);
  assign req_too_long = reach > SUM_W'(ring_time);
  assign adv_full = SUM_W'(new_time) >= SUM_W'(now_time) + SUM_W'(ring_time);
  assign is_check = (action_t'(action) == ACT_CHECK) || (action_t'(action) == ACT_INSERT);

  // End of the request in time, rounded up to a whole slot.
  assign et_time  = st_time + span + TIME_W'(scale_m1);
  assign job_last = (op == ACT_ADVANCE) ? 2'd1 : 2'd2;

  // Each slot number takes two divisions: the time by the ring length, which
  // leaves the position inside the ring, then that remainder by the scale.
  always_comb begin
    if (phase) begin
      div_dvd = TIME_W'(div_rem);
      div_dvs = DVS_W'(eff_scale);
    end else begin
      div_dvs = DVS_W'(ring_time);
      case (job)
        2'd0:    div_dvd = now_time;
        2'd1:    div_dvd = (op == ACT_ADVANCE) ? target_time : st_time;
        default: div_dvd = et_time;
      endcase
    end
  end

  srrc_div #(
    .DVS_W (DVS_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Walk modes: a time advance zeroes slots, a force insert or the second
  // pass of an insert adds, anything else only tests.
  assign clear_mode = op == ACT_ADVANCE;
  assign add_mode   = (op == ACT_FORCE) || ((op == ACT_INSERT) && pass);
  assign issue      = (state == ST_WALK) && (idx < seg_end);
  assign seg_next   = (state == ST_WALK) && !issue && wrap && !second;
  assign walk_end   = (state == ST_WALK) && !issue && !(wrap && !second);

  assign over = ({1'b0, rd_data} + {1'b0, amount}) > {1'b0, capacity};

  // One write per cycle. An add writes the slot read the cycle before while the
  // next slot is read; a walk never visits a slot twice, so the two
  // addresses always differ and no forwarding is needed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = rd_data + amount;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (issue && clear_mode) begin
      mem_we    = 1'b1;
      mem_waddr = idx[IDX_W-1:0];
      mem_wdata = '0;
    end else if (rd_vld && add_mode) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_load[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && !clear_mode) begin
      rd_data <= slot_load[idx[IDX_W-1:0]];
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_scale <= SCALE_W'(1);
      capacity   <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE:    slot_scale <= cfg_data[SCALE_W-1:0];
        REG_CAPACITY: capacity   <= cfg_data[TIME_W-1:0];
        default:      ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == IDX_W'(NUM_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (is_check && req_too_long) begin
            state_next = ST_DONE;
          end else if ((action_t'(action) == ACT_ADVANCE) && adv_full) begin
            state_next = ST_PLAN;
          end else begin
            state_next = ST_GO;
          end
        end
      end
      ST_GO: begin
        div_go     = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (!phase || (job != job_last)) begin
            state_next = ST_GO;
          end else begin
            state_next = ST_PLAN;
          end
        end
      end
      ST_PLAN: state_next = ST_WALK;
      ST_WALK: begin
        if (walk_end) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if ((op == ACT_INSERT) && !pass && !fail) begin
          state_next = ST_PLAN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_time <= '0;
      clr_idx  <= '0;
      job      <= '0;
      phase    <= 1'b0;
      pass     <= 1'b0;
      fail     <= 1'b0;
      wrap     <= 1'b0;
      second   <= 1'b0;
      rd_vld   <= 1'b0;
      full_adv <= 1'b0;
      op       <= ACT_CHECK;
    end else begin
      rd_vld <= issue && !clear_mode;
      if (rd_vld && !add_mode && over) begin
        fail <= 1'b1;
      end
      case (state)
        ST_CLEAR: clr_idx <= clr_idx + IDX_W'(1);
        ST_IDLE: begin
          if (start) begin
            op       <= action_t'(action);
            fail     <= is_check && req_too_long;
            full_adv <= adv_full;
            job      <= '0;
            phase    <= 1'b0;
            pass     <= 1'b0;
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            phase <= !phase;
            if (phase) begin
              job <= job + 2'd1;
            end
          end
        end
        ST_PLAN: second <= 1'b0;
        ST_WALK: begin
          if (seg_next) begin
            second <= 1'b1;
          end
        end
        ST_FIN: begin
          if ((op == ACT_INSERT) && !pass && !fail) begin
            pass <= 1'b1;
          end
        end
        ST_DONE: begin
          if (op == ACT_ADVANCE) begin
            now_time <= target_time;
          end
        end
        default: ;
      endcase
      if (state == ST_PLAN) begin
        if (op == ACT_ADVANCE) begin
          wrap <= !full_adv && (el < tl);
        end else begin
          wrap <= (sl >= tl) && (el <= tl);
        end
      end
    end
  end

  // Payload registers: item fields, slot numbers and walker position.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      st_time     <= now_time + start_offset;
      span        <= span_length;
      amount      <= load_amount;
      target_time <= new_time;
    end
    if ((state == ST_WAIT) && div_done && phase) begin
      case (job)
        2'd0:    tl <= div_q[IDX_W-1:0];
        2'd1: begin
          if (op == ACT_ADVANCE) begin
            el <= div_q[IDX_W-1:0];
          end else begin
            sl <= div_q[IDX_W-1:0];
          end
        end
        default: el <= div_q[IDX_W-1:0];
      endcase
    end
    if (state == ST_PLAN) begin
      if (op == ACT_ADVANCE) begin
        if (full_adv) begin
          // A whole ring or more has gone by: every slot is cleared.
          idx     <= '0;
          seg_end <= CNT_W'(NUM_SLOTS);
        end else if (el > tl) begin
          idx     <= CNT_W'(tl);
          seg_end <= CNT_W'(el);
        end else if (el < tl) begin
          idx     <= CNT_W'(tl);
          seg_end <= CNT_W'(NUM_SLOTS);
        end else begin
          idx     <= CNT_W'(tl);
          seg_end <= CNT_W'(tl);
        end
      end else begin
        idx <= CNT_W'(sl);
        if ((sl >= tl) && (el <= tl)) begin
          seg_end <= CNT_W'(NUM_SLOTS);
        end else begin
          seg_end <= CNT_W'(el);
        end
      end
    end else if (issue) begin
      idx     <= idx + CNT_W'(1);
      rd_addr <= idx[IDX_W-1:0];
    end else if (seg_next) begin
      // The range wraps: continue from slot zero up to the end slot.
      idx     <= '0;
      seg_end <= CNT_W'(el);
    end
  end

  assign busy     = state != ST_IDLE;
  assign done     = state == ST_DONE;
  assign accepted = !fail;

endmodule

/* sv/srrc_div.sv */
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
module srrc_div
  import srrc_pkg::*;
#(
  parameter int DVS_W = SCALE_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [TIME_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              done,
  output logic [TIME_W-1:0] quotient,
  output logic [DVS_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic [CNT_W-1:0] count;
  logic             run;
  logic [DVS_W:0]   trial;
  logic             fits;

  // The partial remainder stays below the divisor, so one extra bit is enough.
  assign trial = {remainder, quotient[TIME_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      run   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        count <= CNT_W'(TIME_W);
        run   <= 1'b1;
      end else if (run) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (run) begin
      quotient  <= {quotient[TIME_W-2:0], fits};
      remainder <= fits ? DVS_W'(trial - {1'b0, divisor}) : DVS_W'(trial);
    end
  end

endmodule

/* sv/srrc_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the calendar and the bind that attaches it.
module srrc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Reset starts the clearing sweep, so the block reports busy.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

  // A transfer into the block makes it busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block idle after taking an item");

  // A result is only given while an item is in work.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result given while idle");

  // After its result the block is free for the next item.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> (!busy && !done))
    else $error("block not idle after a result");

endmodule

bind slotted_resource_reservation_calendar srrc_checker u_srrc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
